// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the adjacency store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SAS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SAS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sas_pkg.sv =====
// Package of types, constants and the microcode table of the adjacency store.
`timescale 1ns / 1ps
package sas_pkg;

  localparam int SAS_MAX_NODES = 32;

  localparam int NODE_W     = 5;
  localparam int CNT_W      = 6;
  localparam int SIZE_W     = 6;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 3;
  localparam int OUT_PAD_W  = OUT_DATA_W - (1 + NODE_W + CNT_W);

  localparam logic [CNT_W-1:0]  LIST_CAP   = 6'd32;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LIST  = 2'd2,
    OP_COUNT = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    U_IDLE, U_CHECK, U_BAD, U_EDGE, U_ROWA, U_SCAN, U_FINAL
  } ustep_t;

  typedef enum logic [2:0] {
    M_NONE, M_RD_PAIR, M_RD_FIRST, M_RD_NEXT, M_WR_EDGE
  } mem_op_t;

  typedef enum logic [2:0] {
    E_NONE, E_BAD, E_EDGE, E_SCAN, E_TOTAL
  } emit_op_t;

  typedef enum logic [2:0] {
    C_GO, C_INPUT, C_DISPATCH, C_OUT, C_SCAN
  } cond_t;

  typedef struct packed {
    logic     take;
    mem_op_t  mem;
    emit_op_t emit;
    cond_t    cond;
    ustep_t   target;
  } uword_t;

  typedef struct packed {
    logic     take;
    mem_op_t  mem;
    emit_op_t emit;
    logic     advance;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic bad;
    logic edge_op;
    logic list_op;
    logic hit;
    logic at_cap;
    logic scan_last;
    logic out_free;
  } stat_t;

  // The program: one control word per step.
  function automatic uword_t ucode(ustep_t step);
    uword_t w;
    unique case (step)
      U_IDLE:  w = '{1'b1, M_NONE,     E_NONE,  C_INPUT,    U_CHECK};
      U_CHECK: w = '{1'b0, M_RD_PAIR,  E_NONE,  C_DISPATCH, U_BAD};
      U_BAD:   w = '{1'b0, M_NONE,     E_BAD,   C_OUT,      U_IDLE};
      U_EDGE:  w = '{1'b0, M_WR_EDGE,  E_EDGE,  C_OUT,      U_IDLE};
      U_ROWA:  w = '{1'b0, M_RD_FIRST, E_NONE,  C_GO,       U_SCAN};
      U_SCAN:  w = '{1'b0, M_RD_NEXT,  E_SCAN,  C_SCAN,     U_FINAL};
      U_FINAL: w = '{1'b0, M_NONE,     E_TOTAL, C_OUT,      U_IDLE};
      default: w = '{1'b0, M_NONE,     E_NONE,  C_GO,       U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/sas_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module sas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                            clk,
  input  logic                                            wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
  input  logic [WIDTH-1:0]                                wr_data,
  input  logic                                            rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
  output logic [WIDTH-1:0]                                rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sas_sequencer.sv =====
// Microcode sequencer: step counter, control word fetch and conditional jumps.
`timescale 1ns / 1ps
module sas_sequencer import sas_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);
  ustep_t step, step_next;
  uword_t uw;
  logic   advance;
  logic   need_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= U_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    uw        = ucode(step);
    need_out  = stat.hit && stat.list_op;
    advance   = 1'b0;
    step_next = step;
    unique case (uw.cond)
      C_GO: begin
        advance   = 1'b1;
        step_next = uw.target;
      end
      C_INPUT: begin
        advance   = stat.in_valid;
        step_next = advance ? uw.target : step;
      end
      C_DISPATCH: begin
        advance = 1'b1;
        if (stat.bad) begin
          step_next = uw.target;
        end else if (stat.edge_op) begin
          step_next = U_EDGE;
        end else begin
          step_next = U_ROWA;
        end
      end
      C_OUT: begin
        advance   = stat.out_free;
        step_next = advance ? uw.target : step;
      end
      C_SCAN: begin
        advance = !need_out || stat.out_free;
        if (!advance) begin
          step_next = step;
        end else if (need_out && stat.at_cap) begin
          step_next = U_IDLE;
        end else if (stat.scan_last) begin
          step_next = uw.target;
        end else begin
          step_next = step;
        end
      end
      default: begin
        advance   = 1'b1;
        step_next = U_IDLE;
      end
    endcase
    ctrl.take    = uw.take;
    ctrl.mem     = uw.mem;
    ctrl.emit    = uw.emit;
    ctrl.advance = advance;
  end

endmodule

// ===== rtl/sas_datapath.sv =====
// Datapath: item fields, edge row memory, scan index, counter and result register.
`timescale 1ns / 1ps
module sas_datapath import sas_pkg::*; #(
  parameter int MAX_NODES = SAS_MAX_NODES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_t                 ctrl,
  output stat_t                 stat,
  input  logic                  cfg_wr_en,
  input  logic [SIZE_W-1:0]     cfg_wr_data,
  input  logic                  s_tvalid,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast
);
  localparam int AW = $clog2(MAX_NODES);

  opcode_t               opcode;
  logic [NODE_W-1:0]     node_a, node_b, lo_node, hi_node;
  logic                  edge_value;
  logic [CNT_W-1:0]      cap_in, cap_eff, cnt;
  logic [SIZE_W-1:0]     active_size, n_eff;
  logic [MAX_NODES-1:0]  row_valid, rowa, rd_data, rd_row, wr_row;
  logic                  rd_valid, rd_en, wr_en, take, fire;
  logic [AW-1:0]         a_idx, lo_idx, hi_idx, scan_i, rd_addr;
  logic                  edge_op, list_op, hit, at_cap, scan_last, out_free;
  logic                  r_es, r_nv, r_last;
  logic [NODE_W-1:0]     r_ni;
  logic [CNT_W-1:0]      r_nt;
  logic [1:0]            r_st;

  assign take   = ctrl.take && s_tvalid;
  assign cap_in = s_tdata[16:11];

  always_ff @(posedge clk) begin
    if (take) begin
      opcode     <= opcode_t'(s_tuser);
      node_a     <= s_tdata[4:0];
      node_b     <= s_tdata[9:5];
      edge_value <= s_tdata[10];
      cap_eff    <= (cap_in > LIST_CAP) ? LIST_CAP : cap_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      active_size <= cfg_wr_data;
    end
  end

  assign n_eff   = (active_size > SIZE_W'(MAX_NODES)) ? SIZE_W'(MAX_NODES) : active_size;
  assign edge_op = (opcode == OP_READ) || (opcode == OP_WRITE);
  assign list_op = (opcode == OP_LIST);
  assign lo_node = (node_a < node_b) ? node_a : node_b;
  assign hi_node = (node_a < node_b) ? node_b : node_a;
  assign a_idx   = AW'(node_a);
  assign lo_idx  = AW'(lo_node);
  assign hi_idx  = AW'(hi_node);

  // A row never written reads as empty.
  assign rd_row = rd_valid ? rd_data : '0;

  always_comb begin
    wr_row         = rd_row;
    wr_row[hi_idx] = edge_value;
  end

  // Below node_a the pair lives in row i at column a, from there on in row a.
  assign hit       = (scan_i < a_idx) ? rd_row[a_idx] : rowa[scan_i];
  assign scan_last = (SIZE_W'(scan_i) + SIZE_W'(1)) == n_eff;
  assign at_cap    = (cnt == cap_eff);
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = '0;
    unique case (ctrl.mem)
      M_NONE: begin
      end
      M_RD_PAIR: begin
        rd_en   = ctrl.advance;
        rd_addr = edge_op ? lo_idx : a_idx;
      end
      M_RD_FIRST: begin
        rd_en = ctrl.advance;
      end
      M_RD_NEXT: begin
        rd_en   = ctrl.advance && !scan_last;
        rd_addr = scan_i + AW'(1);
      end
      M_WR_EDGE: begin
        wr_en = ctrl.advance && (opcode == OP_WRITE);
      end
      default: begin
      end
    endcase
  end

  sas_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_sas_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lo_idx),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[lo_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= row_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem == M_RD_FIRST && ctrl.advance) begin
      rowa   <= rd_row;
      scan_i <= '0;
      cnt    <= '0;
    end else if (ctrl.mem == M_RD_NEXT && ctrl.advance) begin
      scan_i <= scan_i + AW'(1);
      if (hit && !(list_op && at_cap)) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_comb begin
    r_es   = 1'b0;
    r_nv   = 1'b0;
    r_ni   = '0;
    r_nt   = '0;
    r_st   = ST_OK;
    r_last = 1'b1;
    fire   = 1'b0;
    unique case (ctrl.emit)
      E_NONE: begin
      end
      E_BAD: begin
        fire = ctrl.advance;
        r_st = ST_BAD;
      end
      E_EDGE: begin
        fire = ctrl.advance;
        r_es = (opcode == OP_READ) ? rd_row[hi_idx] : 1'b0;
      end
      E_SCAN: begin
        fire = ctrl.advance && hit && list_op;
        if (at_cap) begin
          r_nt = cnt;
          r_st = ST_FULL;
        end else begin
          r_nv   = 1'b1;
          r_ni   = NODE_W'(scan_i);
          r_last = 1'b0;
        end
      end
      E_TOTAL: begin
        fire = ctrl.advance;
        r_nt = cnt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, r_nt, r_ni, r_es};
      m_tuser <= {r_st, r_nv};
      m_tlast <= r_last;
    end
  end

  always_comb begin
    stat.in_valid  = s_tvalid;
    stat.bad       = (SIZE_W'(node_a) >= n_eff) || (edge_op && (SIZE_W'(node_b) >= n_eff));
    stat.edge_op   = edge_op;
    stat.list_op   = list_op;
    stat.hit       = hit;
    stat.at_cap    = at_cap;
    stat.scan_last = scan_last;
    stat.out_free  = out_free;
  end

endmodule

// ===== rtl/symmetric_adjacency_store.sv =====
// Top level of the undirected graph adjacency store.
// An edge read, edge write or bad-index result is registered by the edge or bad step after
// the check step. A list or count reads its row, then scans the indices below the size; over
// its whole scan it gives its final beat from the final step. A new input beat is taken only
// in the idle step. Output stalls hold the step while a result beat waits to be taken.
// Reset (synchronous, active high) empties the graph at once and sets the size to 32.
`timescale 1ns / 1ps
module symmetric_adjacency_store import sas_pkg::*; #(
  parameter int MAX_NODES = SAS_MAX_NODES
) (
  input  logic                  clk,
  input  logic                  rst,
  // Active size register write.
  input  logic                  cfg_wr_en,
  input  logic [SIZE_W-1:0]     cfg_wr_data,
  // Input beats.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // node_a[4:0], node_b[9:5], edge_value[10], capacity[16:11], zero above.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode[1:0].
  input  logic [IN_USER_W-1:0]  s_tuser,
  // Result beats.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // edge_state[0], neighbor_index[5:1], neighbor_total[11:6], zero above.
  output logic [OUT_DATA_W-1:0] m_tdata,
  // neighbor_valid[0], status[2:1].
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast
);

  // The sequencer walks a short program held in the package; each control word
  // selects a memory action, a result to emit and the jump condition, and the
  // datapath reports back the conditions it needs (index check, hit, capacity).
  ctrl_t ctrl;
  stat_t stat;

  // Input beats are only taken in the idle step, so one item is worked on at
  // a time; the result register still lets the last result wait for the sink
  // while the next beat is taken.
  assign s_tready = ctrl.take;

  sas_sequencer u_sas_sequencer (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // The datapath keeps each unordered pair once, in the row of the smaller
  // index, and scans the neighbours of a node by reading its own row once
  // and then one lower row per step for the indices below it.
  sas_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_sas_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

// ===== rtl/sas_checker.sv =====
// Port-level checker of the adjacency store, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sas_checker import sas_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser,
  input logic                  m_tlast
);

  // A stalled result beat holds its contents.
  `SAS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

  // Only one item is worked on at a time.
  `SAS_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")

  // A bad index answer is a lone final beat with every other field clear.
  `SAS_ASSERT_IMPL(a_bad_alone, clk, rst, m_tvalid && m_tuser[2:1] == ST_BAD, m_tlast && m_tdata == '0 && !m_tuser[0], "bad index beat carries data")

  // A neighbour beat is never final, and carries status ok and no total.
  `SAS_ASSERT_IMPL(a_neighbour_beat, clk, rst, m_tvalid && m_tuser[0], !m_tlast && m_tuser[2:1] == ST_OK && m_tdata[11:6] == '0, "malformed neighbour beat")

endmodule

bind symmetric_adjacency_store sas_checker u_sas_checker (.*);

// ===== sim/tb_symmetric_adjacency_store.sv =====
// Self-checking testbench for the undirected graph adjacency store.
`timescale 1ns / 1ps
module tb_symmetric_adjacency_store;
  import sas_pkg::*;

  // One result beat as the block reports it, fields in the order they are compared.
  typedef struct packed {
    logic              edge_state;
    logic              neighbor_valid;
    logic [NODE_W-1:0] neighbor_index;
    logic [CNT_W-1:0]  neighbor_total;
    logic [1:0]        status;
    logic              last;
  } graph_result_t;

  // One row of the directed table. A row either rewrites the active size or sends one
  // operation; where typed is set, the single result is written out in the row itself.
  typedef struct packed {
    logic              size_row;
    logic [SIZE_W-1:0] size;
    opcode_t           op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              edge_value;
    logic [CNT_W-1:0]  capacity;
    logic              typed;
    graph_result_t     result;
  } graph_vector_t;

  localparam graph_result_t RES_OK    = '{1'b0, 1'b0, 5'd0, 6'd0, ST_OK, 1'b1};
  localparam graph_result_t RES_BAD   = '{1'b0, 1'b0, 5'd0, 6'd0, ST_BAD, 1'b1};
  localparam graph_result_t RES_FULL0 = '{1'b0, 1'b0, 5'd0, 6'd0, ST_FULL, 1'b1};
  localparam graph_result_t RES_NONE  = '0;

  localparam int N_DIRECTED = 26;
  localparam int N_PHASES   = 7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0]     cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  // Our own copy of the graph: row lo holds the pair {lo, hi} at column hi.
  logic [SAS_MAX_NODES-1:0] adj_rows [SAS_MAX_NODES];
  logic [SIZE_W-1:0]        graph_size;

  graph_result_t expected_beats [$];
  graph_result_t beat_buf [$];
  graph_vector_t directed_rows [N_DIRECTED];

  int phase_sizes [N_PHASES] = '{32, 63, 1, 0, 13, 2, 0};
  int phase_items [N_PHASES] = '{60, 40, 25, 10, 50, 40, 55};

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int fail_count   = 0;
  int items_sent   = 0;
  int beats_checked = 0;
  int lists_full   = 0;
  int size_writes  = 0;

  symmetric_adjacency_store u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Each unordered pair lives once, in the row of the smaller index.
  function automatic logic edge_bit(logic [NODE_W-1:0] x, logic [NODE_W-1:0] y);
    return (x < y) ? adj_rows[x][y] : adj_rows[y][x];
  endfunction

  // Works out every result beat that one operation causes and leaves them in beat_buf.
  // A write also updates our copy of the graph.
  function automatic void predict_graph_op(opcode_t op, logic [NODE_W-1:0] a,
                                           logic [NODE_W-1:0] b, logic v,
                                           logic [CNT_W-1:0] cap);
    int eff;
    int limit;
    int found;
    beat_buf.delete();
    eff = (graph_size > SAS_MAX_NODES) ? SAS_MAX_NODES : int'(graph_size);
    if (a >= eff || ((op == OP_READ || op == OP_WRITE) && b >= eff)) begin
      beat_buf.push_back(RES_BAD);
      return;
    end
    found = 0;
    case (op)
      OP_READ: begin
        beat_buf.push_back({edge_bit(a, b), 1'b0, 5'd0, 6'd0, ST_OK, 1'b1});
      end
      OP_WRITE: begin
        if (a < b) adj_rows[a][b] = v;
        else adj_rows[b][a] = v;
        beat_buf.push_back(RES_OK);
      end
      OP_COUNT: begin
        for (int i = 0; i < eff; i++) found += edge_bit(a, i[NODE_W-1:0]);
        beat_buf.push_back({1'b0, 1'b0, 5'd0, found[CNT_W-1:0], ST_OK, 1'b1});
      end
      default: begin
        // A capacity beyond 32 behaves as 32, so a list never exceeds 33 beats.
        limit = (cap > LIST_CAP) ? int'(LIST_CAP) : int'(cap);
        for (int i = 0; i < eff; i++) begin
          if (edge_bit(a, i[NODE_W-1:0])) begin
            if (found == limit) begin
              beat_buf.push_back({1'b0, 1'b0, 5'd0, found[CNT_W-1:0], ST_FULL, 1'b1});
              return;
            end
            beat_buf.push_back({1'b0, 1'b1, i[NODE_W-1:0], 6'd0, ST_OK, 1'b0});
            found++;
          end
        end
        beat_buf.push_back({1'b0, 1'b0, 5'd0, found[CNT_W-1:0], ST_OK, 1'b1});
      end
    endcase
  endfunction

  // Mostly pick a node inside the active size, now and then anything the field holds.
  function automatic logic [NODE_W-1:0] pick_node(int eff);
    if (eff > 0 && $urandom_range(99) < 90) return NODE_W'($urandom_range(eff - 1));
    return NODE_W'($urandom_range(SAS_MAX_NODES - 1));
  endfunction

  // Presents one operation beat and holds it until the block takes it. The expected
  // results are queued at the edge of acceptance. Valid is lowered only when a gap
  // follows or nothing else is to be sent straight away.
  task automatic send_op(opcode_t op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                         logic v, logic [CNT_W-1:0] cap, bit keep_valid,
                         bit typed, graph_result_t typed_result);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - 17){1'b0}}, cap, v, b, a};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predict_graph_op(op, a, b, v, cap);
    if (typed) expected_beats.push_back(typed_result);
    else foreach (beat_buf[i]) expected_beats.push_back(beat_buf[i]);
    items_sent++;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0 || !keep_valid) s_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // The size register is only rewritten once the block has drained every result;
  // a short settle covers the step back to idle after the final beat.
  task automatic set_active_size(logic [SIZE_W-1:0] size);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    graph_size = size;
    size_writes++;
  endtask

  // Result side: check whatever was taken at this edge against the oldest expectation,
  // then decide whether to stall for the next cycle.
  always @(posedge clk) begin
    graph_result_t got;
    graph_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tuser[0], m_tdata[5:1], m_tdata[11:6], m_tuser[2:1], m_tlast};
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: data %h user %h last %b",
               m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (got.status == ST_FULL) lists_full++;
        if (got.edge_state !== want.edge_state) begin
          $error("edge_state: expected %0d, got %0d", want.edge_state, got.edge_state);
          fail_count++;
        end
        if (got.neighbor_valid !== want.neighbor_valid) begin
          $error("neighbor_valid: expected %0d, got %0d",
                 want.neighbor_valid, got.neighbor_valid);
          fail_count++;
        end
        if (got.neighbor_index !== want.neighbor_index) begin
          $error("neighbor_index: expected %0d, got %0d",
                 want.neighbor_index, got.neighbor_index);
          fail_count++;
        end
        if (got.neighbor_total !== want.neighbor_total) begin
          $error("neighbor_total: expected %0d, got %0d",
                 want.neighbor_total, got.neighbor_total);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          fail_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Main sequence: reset, the directed table, then random phases over several sizes
  // and idling patterns, and finally the drain and the verdict.
  initial begin
    opcode_t           op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic              v;
    logic [CNT_W-1:0]  cap;
    int                eff;
    int                r;
    int                wait_cycles;

    foreach (adj_rows[i]) adj_rows[i] = '0;
    graph_size = SIZE_RESET;

    // The first rows read an empty graph, then edges are laid down around node 0 and
    // node 31, including the self loop on 31, before lists are cut short at capacity
    // zero and two. Later rows shrink the size to one node and to none, where indices
    // turn bad, and finally set a size beyond the node count.
    directed_rows = '{
      '{1'b0, 6'd0,  OP_READ,  5'd0,  5'd0,  1'b0, 6'd0,  1'b1, RES_OK},
      '{1'b0, 6'd0,  OP_READ,  5'd31, 5'd0,  1'b0, 6'd0,  1'b1, RES_OK},
      '{1'b0, 6'd0,  OP_COUNT, 5'd31, 5'd0,  1'b0, 6'd0,  1'b1, RES_OK},
      '{1'b0, 6'd0,  OP_LIST,  5'd0,  5'd0,  1'b0, 6'd32, 1'b1, RES_OK},
      '{1'b0, 6'd0,  OP_WRITE, 5'd0,  5'd31, 1'b1, 6'd0,  1'b1, RES_OK},
      '{1'b0, 6'd0,  OP_WRITE, 5'd31, 5'd31, 1'b1, 6'd0,  1'b1, RES_OK},
      '{1'b0, 6'd0,  OP_WRITE, 5'd5,  5'd0,  1'b1, 6'd0,  1'b1, RES_OK},
      '{1'b0, 6'd0,  OP_WRITE, 5'd0,  5'd17, 1'b1, 6'd0,  1'b1, RES_OK},
      '{1'b0, 6'd0,  OP_READ,  5'd31, 5'd0,  1'b0, 6'd0,  1'b0, RES_NONE},
      '{1'b0, 6'd0,  OP_LIST,  5'd31, 5'd0,  1'b0, 6'd63, 1'b0, RES_NONE},
      '{1'b0, 6'd0,  OP_LIST,  5'd0,  5'd0,  1'b0, 6'd0,  1'b1, RES_FULL0},
      '{1'b0, 6'd0,  OP_LIST,  5'd0,  5'd0,  1'b0, 6'd2,  1'b0, RES_NONE},
      '{1'b0, 6'd0,  OP_COUNT, 5'd0,  5'd0,  1'b0, 6'd0,  1'b0, RES_NONE},
      '{1'b0, 6'd0,  OP_WRITE, 5'd31, 5'd31, 1'b0, 6'd0,  1'b1, RES_OK},
      '{1'b0, 6'd0,  OP_LIST,  5'd31, 5'd0,  1'b0, 6'd32, 1'b0, RES_NONE},
      '{1'b1, 6'd1,  OP_READ,  5'd0,  5'd0,  1'b0, 6'd0,  1'b0, RES_NONE},
      '{1'b0, 6'd0,  OP_READ,  5'd0,  5'd0,  1'b0, 6'd0,  1'b0, RES_NONE},
      '{1'b0, 6'd0,  OP_READ,  5'd0,  5'd1,  1'b0, 6'd0,  1'b1, RES_BAD},
      '{1'b0, 6'd0,  OP_WRITE, 5'd1,  5'd0,  1'b1, 6'd0,  1'b1, RES_BAD},
      '{1'b0, 6'd0,  OP_LIST,  5'd1,  5'd0,  1'b0, 6'd5,  1'b1, RES_BAD},
      '{1'b0, 6'd0,  OP_COUNT, 5'd0,  5'd0,  1'b0, 6'd0,  1'b0, RES_NONE},
      '{1'b1, 6'd0,  OP_READ,  5'd0,  5'd0,  1'b0, 6'd0,  1'b0, RES_NONE},
      '{1'b0, 6'd0,  OP_READ,  5'd0,  5'd0,  1'b0, 6'd0,  1'b1, RES_BAD},
      '{1'b1, 6'd63, OP_READ,  5'd0,  5'd0,  1'b0, 6'd0,  1'b0, RES_NONE},
      '{1'b0, 6'd0,  OP_LIST,  5'd0,  5'd31, 1'b0, 6'd40, 1'b0, RES_NONE},
      '{1'b0, 6'd0,  OP_COUNT, 5'd31, 5'd0,  1'b0, 6'd0,  1'b0, RES_NONE}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].size_row) begin
        set_active_size(directed_rows[i].size);
      end else begin
        send_op(directed_rows[i].op, directed_rows[i].node_a, directed_rows[i].node_b,
                directed_rows[i].edge_value, directed_rows[i].capacity,
                (i + 1 < N_DIRECTED) && !directed_rows[i + 1].size_row,
                directed_rows[i].typed, directed_rows[i].result);
      end
    end

    // The last phase runs at a size chosen by the seed.
    phase_sizes[N_PHASES - 1] = $urandom_range(3, 31);

    for (int p = 0; p < N_PHASES; p++) begin
      set_active_size(phase_sizes[p][SIZE_W-1:0]);
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 59;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 59;
        end
        default: begin
          tx_idle_pct  = 33;
          rx_stall_pct = 33;
        end
      endcase
      eff = (graph_size > SAS_MAX_NODES) ? SAS_MAX_NODES : int'(graph_size);
      for (int k = 0; k < phase_items[p]; k++) begin
        // Writes lean towards setting edges so that lists and counts have work to do.
        r = $urandom_range(99);
        if (r < 20) op = OP_READ;
        else if (r < 60) op = OP_WRITE;
        else if (r < 85) op = OP_LIST;
        else op = OP_COUNT;
        a = pick_node(eff);
        b = pick_node(eff);
        v = ($urandom_range(99) < 70);
        r = $urandom_range(99);
        if (r < 30) cap = CNT_W'($urandom_range(3));
        else if (r < 60) cap = CNT_W'($urandom_range(32));
        else cap = CNT_W'($urandom_range(63));
        send_op(op, a, b, v, cap, k + 1 < phase_items[p], 1'b0, RES_NONE);
      end
    end

    wait_cycles = 0;
    while (expected_beats.size() != 0 && wait_cycles < 50000) begin
      @(posedge clk);
      wait_cycles++;
    end
    // Leave room for a full scan over 32 nodes to finish and catch any stray beats.
    repeat (40) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $error("%0d result beats never arrived", expected_beats.size());
      fail_count++;
    end

    $display("Sent %0d operations across %0d size settings; %0d result beats compared.",
             items_sent, size_writes + 1, beats_checked);
    $display("Neighbour lists stopped at their capacity: %0d.", lists_full);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest run the stimulus above can produce.
  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sas_pkg.sv
rtl/sas_ram.sv
rtl/sas_sequencer.sv
rtl/sas_datapath.sv
rtl/symmetric_adjacency_store.sv
rtl/sas_checker.sv
sim/tb_symmetric_adjacency_store.sv
